/* design/sac_pkg.sv */
// sac_pkg: shared types, widths and constants of the signal activity checker
// no dependencies; imported by sac_run, sac_result and signal_activity_checker_top
`default_nettype none

package sac_pkg;

	localparam int unsigned MEAN_COUNT   = 1000;
	localparam int unsigned WINDOW_COUNT = 8000;
	localparam int unsigned CHANNELS_DEF = 16;
	localparam int unsigned SAMPLE_BITS  = 12;

	localparam int unsigned OP_W  = 2;
	localparam int unsigned CH_W  = 4;
	localparam int unsigned SMP_W = 12;
	localparam int unsigned ACC_W = 25;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned LEN_W = CNT_W + 1;

	localparam logic [SMP_W-1:0] SMP_MAX  = {SMP_W{1'b1}};
	localparam logic [SMP_W-1:0] SMP_MASK = (SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} :
		SMP_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};

	localparam logic [LEN_W-1:0] MEAN_LEN   = LEN_W'(MEAN_COUNT);
	localparam logic [LEN_W-1:0] WINDOW_LEN = LEN_W'(WINDOW_COUNT);

	// floor(acc / MEAN_COUNT) as (acc * RECIP) >> DIV_SHIFT, exact over the accumulator range
	localparam int unsigned DIV_L      = $clog2(MEAN_COUNT);
	localparam int unsigned DIV_SHIFT  = ACC_W + DIV_L;
	localparam int unsigned RECIP_W    = ACC_W + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << DIV_SHIFT) + 64'(MEAN_COUNT) - 64'd1) / 64'(MEAN_COUNT);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam int unsigned PROD_W = ACC_W + RECIP_W;
	localparam int unsigned QUO_W  = PROD_W - DIV_SHIFT;

	typedef enum logic [OP_W-1:0] {
		PH_MEAN    = 2'd0,
		PH_STATIC  = 2'd1,
		PH_DYNAMIC = 2'd2
	} phase_t;

	// opcode with no phase; such items are taken and dropped
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [CH_W-1:0]  channel;
		logic [SMP_W-1:0] sample;
	} sample_t;

	typedef struct packed {
		logic [OP_W-1:0]  phase_done;
		logic [CH_W-1:0]  channel_done;
		logic [SMP_W-1:0] level_mean;
		logic [SMP_W-1:0] run_minimum;
		logic [SMP_W-1:0] run_maximum;
		logic [ACC_W-1:0] deviation_sum;
		logic             activity_fail;
	} result_t;

	// completed run handed from the run stage to the result stages
	typedef struct packed {
		logic [OP_W-1:0]  phase;
		logic [CH_W-1:0]  channel;
		logic [SMP_W-1:0] low;
		logic [SMP_W-1:0] high;
		logic [ACC_W-1:0] sum;
		logic [SMP_W-1:0] mean;
		logic [ACC_W-1:0] static_sum;
	} done_t;

	// write-back to the per-channel stores
	typedef struct packed {
		logic             mean_we;
		logic             static_we;
		logic [CH_W-1:0]  channel;
		logic [SMP_W-1:0] mean;
		logic [ACC_W-1:0] sum;
	} wb_t;

endpackage

`default_nettype wire

/* design/sac_store.sv */
// sac_store: per-channel store with registered synchronous read and valid bits
// unwritten entries read as zero; write-first bypass and update of the held read
`default_nettype none

module sac_store #(
	parameter int unsigned WIDTH  = 12,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic [ADDR_W-1:0] hold_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// the held read follows a write to its entry so the consumer never sees stale data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_q <= wr_data;
			end else if (vld_q[rd_addr]) begin
				rd_q <= mem[rd_addr];
			end else begin
				rd_q <= '0;
			end
		end else if (wr_en && wr_addr == hold_addr) begin
			rd_q <= wr_data;
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

/* design/sac_run.sv */
// sac_run: first stage register and the running run state (count, min, max, sum)
// depends on sac_pkg; operands come from the two sac_store instances
`default_nettype none

module sac_run (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  sac_pkg::sample_t          item,
	input  logic                      go,
	input  logic [sac_pkg::SMP_W-1:0] mean_rd,
	input  logic [sac_pkg::ACC_W-1:0] static_rd,
	output logic                      valid_s1,
	output logic [sac_pkg::CH_W-1:0]  channel_s1,
	output logic                      complete,
	output sac_pkg::done_t            done
);

	import sac_pkg::*;

	logic [OP_W-1:0]  opcode_s1;
	logic [SMP_W-1:0] sample_s1;

	logic [OP_W-1:0]  run_phase_q;
	logic [CH_W-1:0]  run_channel_q;
	logic [CNT_W-1:0] run_count_q;
	logic [SMP_W-1:0] run_low_q;
	logic [SMP_W-1:0] run_high_q;
	logic [ACC_W-1:0] run_acc_q;

	logic             new_run;
	logic             is_mean;
	logic [CNT_W-1:0] cnt_b;
	logic [SMP_W-1:0] low_b;
	logic [SMP_W-1:0] high_b;
	logic [ACC_W-1:0] acc_b;
	logic [SMP_W-1:0] smp;
	logic [SMP_W-1:0] dev;
	logic [SMP_W-1:0] add_val;
	logic [ACC_W:0]   sum_w;
	logic [ACC_W-1:0] acc_n;
	logic [CNT_W-1:0] cnt_n;
	logic [SMP_W-1:0] low_n;
	logic [SMP_W-1:0] high_n;
	logic [LEN_W-1:0] len;

	always_comb begin
		new_run = (opcode_s1 != run_phase_q) || (channel_s1 != run_channel_q);
		is_mean = (opcode_s1 == PH_MEAN);
		cnt_b   = new_run ? '0 : run_count_q;
		low_b   = new_run ? SMP_MAX : run_low_q;
		high_b  = new_run ? '0 : run_high_q;
		acc_b   = new_run ? '0 : run_acc_q;
		smp     = sample_s1 & SMP_MASK;
		dev     = (smp > mean_rd) ? (smp - mean_rd) : (mean_rd - smp);
		add_val = is_mean ? smp : dev;
		sum_w   = {1'b0, acc_b} + {{(ACC_W + 1 - SMP_W){1'b0}}, add_val};
		acc_n   = sum_w[ACC_W] ? ACC_MAX : sum_w[ACC_W-1:0];
		cnt_n   = cnt_b + CNT_W'(1);
		low_n   = (!is_mean && smp < low_b) ? smp : low_b;
		high_n  = (!is_mean && smp > high_b) ? smp : high_b;
		len     = is_mean ? MEAN_LEN : WINDOW_LEN;
		complete = valid_s1 && ({1'b0, cnt_n} >= len);
	end

	always_comb begin
		done.phase      = opcode_s1;
		done.channel    = channel_s1;
		done.low        = low_n;
		done.high       = high_n;
		done.sum        = acc_n;
		done.mean       = mean_rd;
		done.static_sum = static_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			opcode_s1  <= item.opcode;
			channel_s1 <= item.channel;
			sample_s1  <= item.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_phase_q   <= '0;
			run_channel_q <= '0;
			run_count_q   <= '0;
			run_low_q     <= SMP_MAX;
			run_high_q    <= '0;
			run_acc_q     <= '0;
		end else if (go) begin
			run_phase_q   <= opcode_s1;
			run_channel_q <= channel_s1;
			if (complete) begin
				run_count_q <= '0;
				run_low_q   <= SMP_MAX;
				run_high_q  <= '0;
				run_acc_q   <= '0;
			end else begin
				run_count_q <= cnt_n;
				run_low_q   <= low_n;
				run_high_q  <= high_n;
				run_acc_q   <= acc_n;
			end
		end
	end

endmodule

`default_nettype wire

/* design/sac_result.sv */
// sac_result: completed runs -> mean division, activity compare, output register
// depends on sac_pkg; drives the store write-back at the output handshake
`default_nettype none

module sac_result (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  sac_pkg::done_t            done,
	input  logic [sac_pkg::ACC_W-1:0] margin,
	input  logic                      stall,
	output logic                      s2_free,
	output logic                      wpend,
	output logic                      res_valid,
	output sac_pkg::result_t          res_data,
	output sac_pkg::wb_t              wb
);

	import sac_pkg::*;

	logic             valid_s2;
	done_t            done_s2;
	logic             s2_move;
	logic             s3_free;
	logic [PROD_W-1:0] prod_w;
	logic             ok_s2;
	logic             fail_w;

	logic              valid_s3;
	logic [OP_W-1:0]   phase_s3;
	logic [CH_W-1:0]   channel_s3;
	logic [SMP_W-1:0]  low_s3;
	logic [SMP_W-1:0]  high_s3;
	logic [ACC_W-1:0]  sum_s3;
	logic [SMP_W-1:0]  mean_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              fail_s3;

	logic [QUO_W-1:0] quo;
	logic [SMP_W-1:0] mean_new;
	logic             is_mean_s3;
	logic             fire;

	assign s3_free = !valid_s3 || !stall;
	assign s2_move = valid_s2 && s3_free;
	assign s2_free = !valid_s2 || s2_move;

	// mean and static results rewrite a store; the run stage waits until they land
	assign wpend = (valid_s2 && done_s2.phase != PH_DYNAMIC) ||
		(valid_s3 && phase_s3 != PH_DYNAMIC);

	always_comb begin
		prod_w = PROD_W'(done_s2.sum) * PROD_W'(RECIP);
		ok_s2  = (done_s2.sum > done_s2.static_sum) &&
			((done_s2.sum - done_s2.static_sum) > margin);
		fail_w = (done_s2.phase == PH_DYNAMIC) && !ok_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (push) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			done_s2 <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= s2_move || (valid_s3 && stall);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			phase_s3   <= done_s2.phase;
			channel_s3 <= done_s2.channel;
			low_s3     <= done_s2.low;
			high_s3    <= done_s2.high;
			sum_s3     <= done_s2.sum;
			mean_s3    <= done_s2.mean;
			prod_s3    <= prod_w;
			fail_s3    <= fail_w;
		end
	end

	always_comb begin
		quo        = prod_s3[PROD_W-1:DIV_SHIFT];
		mean_new   = (quo > QUO_W'(SMP_MAX)) ? SMP_MAX : quo[SMP_W-1:0];
		is_mean_s3 = (phase_s3 == PH_MEAN);
		fire       = valid_s3 && !stall;

		res_data.phase_done    = phase_s3;
		res_data.channel_done  = channel_s3;
		res_data.level_mean    = is_mean_s3 ? mean_new : mean_s3;
		res_data.run_minimum   = is_mean_s3 ? '0 : low_s3;
		res_data.run_maximum   = is_mean_s3 ? '0 : high_s3;
		res_data.deviation_sum = is_mean_s3 ? '0 : sum_s3;
		res_data.activity_fail = fail_s3;

		wb.mean_we   = fire && is_mean_s3;
		wb.static_we = fire && (phase_s3 == PH_STATIC);
		wb.channel   = channel_s3;
		wb.mean      = mean_new;
		wb.sum       = sum_s3;
	end

	assign res_valid = valid_s3;

endmodule

`default_nettype wire

/* design/signal_activity_checker_top.sv */
// signal_activity_checker_top: channel handshakes, margin register and the stage wiring
// depends on sac_pkg, sac_store, sac_run and sac_result
`default_nettype none

// Samples are taken one per cycle while smp_stall is low. An accepted sample is held in
// the first stage register until it updates the run; a run that completes passes through
// the result stage into the output register, where it is held until taken.
// The per-channel mean and static sum live in two small synchronous stores, read when
// a sample is accepted. When a mean or static run completes, intake pauses until its
// result is taken and written back to the store; a stalled output prolongs the pause.
// Dynamic runs do not wait for a store write-back. Items with opcode three or a channel
// at or above CHANNELS are taken and dropped. The stores need no clearing pass: entries
// never written read as zero from reset.
module signal_activity_checker_top #(
	parameter int unsigned CHANNELS = sac_pkg::CHANNELS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      smp_valid,
	output logic                      smp_stall,
	input  sac_pkg::sample_t          smp_data,
	output logic                      res_valid,
	input  logic                      res_stall,
	output sac_pkg::result_t          res_data,
	input  logic                      margin_we,
	input  logic [sac_pkg::ACC_W-1:0] margin_wdata
);

	import sac_pkg::*;

	localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [ACC_W-1:0] margin_q;
	logic             accept;
	logic             item_ok;
	logic             load;
	logic             s1_go;
	logic             valid_s1;
	logic [CH_W-1:0]  channel_s1;
	logic             complete;
	done_t            done;
	logic             s2_free;
	logic             wpend;
	wb_t              wb;
	logic [SMP_W-1:0] mean_rd;
	logic [ACC_W-1:0] static_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (margin_we) begin
			margin_q <= margin_wdata;
		end
	end

	assign item_ok   = (smp_data.opcode != OP_UNUSED) &&
		(32'(smp_data.channel) < 32'(CHANNELS));
	assign s1_go     = valid_s1 && s2_free && !wpend;
	assign smp_stall = valid_s1 && !s1_go;
	assign accept    = smp_valid && !smp_stall;
	assign load      = accept && item_ok;

	sac_store #(
		.WIDTH  (SMP_W),
		.DEPTH  (CHANNELS),
		.ADDR_W (ADDR_W)
	) u_mean_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (load),
		.rd_addr   (ADDR_W'(smp_data.channel)),
		.hold_addr (ADDR_W'(channel_s1)),
		.wr_en     (wb.mean_we),
		.wr_addr   (ADDR_W'(wb.channel)),
		.wr_data   (wb.mean),
		.rd_data   (mean_rd)
	);

	sac_store #(
		.WIDTH  (ACC_W),
		.DEPTH  (CHANNELS),
		.ADDR_W (ADDR_W)
	) u_static_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (load),
		.rd_addr   (ADDR_W'(smp_data.channel)),
		.hold_addr (ADDR_W'(channel_s1)),
		.wr_en     (wb.static_we),
		.wr_addr   (ADDR_W'(wb.channel)),
		.wr_data   (wb.sum),
		.rd_data   (static_rd)
	);

	sac_run u_run (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.item       (smp_data),
		.go         (s1_go),
		.mean_rd    (mean_rd),
		.static_rd  (static_rd),
		.valid_s1   (valid_s1),
		.channel_s1 (channel_s1),
		.complete   (complete),
		.done       (done)
	);

	sac_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_go && complete),
		.done      (done),
		.margin    (margin_q),
		.stall     (res_stall),
		.s2_free   (s2_free),
		.wpend     (wpend),
		.res_valid (res_valid),
		.res_data  (res_data),
		.wb        (wb)
	);

	// a store write-back and a run update never share an edge
	assert property (@(posedge clk) disable iff (!arst_n)
		(wb.mean_we || wb.static_we) |-> !s1_go)
		else $error("store write-back overlaps run update");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.phase_done == PH_MEAN) |->
		(res_data.run_minimum == '0 && res_data.run_maximum == '0 &&
		res_data.deviation_sum == '0 && !res_data.activity_fail))
		else $error("mean result carries window fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.activity_fail) |-> (res_data.phase_done == PH_DYNAMIC))
		else $error("activity fail on a non-dynamic run");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.phase_done != PH_MEAN) |->
		(res_data.run_minimum <= res_data.run_maximum))
		else $error("window minimum above maximum");

endmodule

`default_nettype wire
